FILE: design/assert_macros.svh
// Assertion macros used by the debounced quadrature encoder top level.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define DQE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define DQE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: design/dqe_pkg.sv
// Shared types, constants and the quadrature transition table of the
// debounced quadrature encoder. No dependencies.
package dqe_pkg;

   // Width of the timestamp arithmetic (valid range 8 to 32).
   localparam int TIME_WIDTH = 32;

   localparam logic [7:0] AB_HOLD_RESET     = 8'd2;
   localparam logic [7:0] SWITCH_HOLD_RESET = 8'd10;

   // Register indexes on the configuration port.
   localparam logic REG_AB_HOLD     = 1'b0;
   localparam logic REG_SWITCH_HOLD = 1'b1;

   typedef logic [TIME_WIDTH-1:0] time_type;

   typedef enum logic [1:0] {
      DIR_NONE  = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_LEFT  = 2'd2
   } dir_type;

   typedef struct packed {
      logic        level_a;
      logic        level_b;
      logic        level_switch;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic step_right;
      logic step_left;
      logic click;
      logic switch_held;
   } rsp_type;

   typedef struct packed {
      logic [7:0] ab_hold_ms;
      logic [7:0] switch_hold_ms;
   } cfg_type;

   // Direction for a move from the old stable pair (upper bits) to the new
   // pair (lower bits). Pair encoding is {A, B}.
   function automatic dir_type quad_dir(input logic [3:0] idx);
      dir_type dir;
      case (idx) inside
         4'd2, 4'd4, 4'd11, 4'd13: dir = DIR_RIGHT;
         4'd1, 4'd7, 4'd8, 4'd14:  dir = DIR_LEFT;
         default:                  dir = DIR_NONE;
      endcase
      return dir;
   endfunction

endpackage

FILE: design/dqe_csr.sv
// Configuration registers of the debounced quadrature encoder on an APB port.
// Depends on dqe_pkg for the register type, indexes and reset values.
module dqe_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output dqe_pkg::cfg_type cfg
);

   logic [7:0] ab_hold_ff, ab_hold_in;
   logic [7:0] switch_hold_ff, switch_hold_in;
   logic       write_en;
   logic       reg_index;

   assign pready    = 1'b1;
   assign write_en  = psel && penable && pwrite && pready;
   assign reg_index = paddr[2];

   // Register write decode; only the low byte of the write data is kept.
   always_comb begin
      ab_hold_in     = ab_hold_ff;
      switch_hold_in = switch_hold_ff;
      if (write_en) begin
         unique case (reg_index)
            dqe_pkg::REG_AB_HOLD:     ab_hold_in     = pwdata[7:0];
            dqe_pkg::REG_SWITCH_HOLD: switch_hold_in = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ab_hold_ff     <= dqe_pkg::AB_HOLD_RESET;
         switch_hold_ff <= dqe_pkg::SWITCH_HOLD_RESET;
      end else begin
         ab_hold_ff     <= ab_hold_in;
         switch_hold_ff <= switch_hold_in;
      end
   end

   // Read data, zero extended.
   always_comb begin
      unique case (reg_index)
         dqe_pkg::REG_AB_HOLD:     prdata = {24'd0, ab_hold_ff};
         dqe_pkg::REG_SWITCH_HOLD: prdata = {24'd0, switch_hold_ff};
         default:                  prdata = 32'd0;
      endcase
   end

   assign cfg.ab_hold_ms     = ab_hold_ff;
   assign cfg.switch_hold_ms = switch_hold_ff;

endmodule

FILE: design/dqe_core.sv
// Debounce state and step/click decision for one poll item.
// Depends on dqe_pkg for payload types, the time width and the direction table.
module dqe_core (
   input  logic             clock,
   input  logic             reset,
   input  dqe_pkg::cfg_type cfg,
   input  dqe_pkg::req_type item,
   input  logic             update,
   output dqe_pkg::rsp_type result
);

   logic [1:0]        stable_pair_ff, stable_pair_in;
   logic [1:0]        last_pair_ff, last_pair_in;
   dqe_pkg::time_type pair_time_ff, pair_time_in;
   logic              stable_switch_ff, stable_switch_in;
   logic              last_switch_ff, last_switch_in;
   dqe_pkg::time_type switch_time_ff, switch_time_in;
   logic              pressed_ff, pressed_in;

   dqe_pkg::time_type now;
   dqe_pkg::time_type pair_elapsed;
   dqe_pkg::time_type switch_elapsed;
   logic [1:0]        raw_pair;
   logic              pair_accept;
   logic              switch_accept;
   dqe_pkg::dir_type  dir;

   assign now            = item.now_ms[dqe_pkg::TIME_WIDTH-1:0];
   assign raw_pair       = {item.level_a, item.level_b};
   assign pair_elapsed   = now - pair_time_ff;
   assign switch_elapsed = now - switch_time_ff;

   // A pair is taken once it matches the last sample, has held long enough
   // and differs from the stable pair.
   assign pair_accept = (raw_pair == last_pair_ff)
                     && (pair_elapsed >= dqe_pkg::time_type'(cfg.ab_hold_ms))
                     && (raw_pair != stable_pair_ff);
   assign switch_accept = (item.level_switch == last_switch_ff)
                       && (switch_elapsed >= dqe_pkg::time_type'(cfg.switch_hold_ms))
                       && (item.level_switch != stable_switch_ff);

   assign dir = dqe_pkg::quad_dir({stable_pair_ff, raw_pair});

   // Next state of both debouncers; a raw change restarts the hold time.
   always_comb begin
      stable_pair_in   = stable_pair_ff;
      last_pair_in     = last_pair_ff;
      pair_time_in     = pair_time_ff;
      stable_switch_in = stable_switch_ff;
      last_switch_in   = last_switch_ff;
      switch_time_in   = switch_time_ff;
      pressed_in       = pressed_ff;
      if (update) begin
         if (raw_pair != last_pair_ff) begin
            last_pair_in = raw_pair;
            pair_time_in = now;
         end else if (pair_accept) begin
            stable_pair_in = raw_pair;
         end
         if (item.level_switch != last_switch_ff) begin
            last_switch_in = item.level_switch;
            switch_time_in = now;
         end else if (switch_accept) begin
            stable_switch_in = item.level_switch;
            pressed_in       = !item.level_switch;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_pair_ff   <= 2'b00;
         last_pair_ff     <= 2'b00;
         pair_time_ff     <= '0;
         stable_switch_ff <= 1'b1;
         last_switch_ff   <= 1'b1;
         switch_time_ff   <= '0;
         pressed_ff       <= 1'b0;
      end else begin
         stable_pair_ff   <= stable_pair_in;
         last_pair_ff     <= last_pair_in;
         pair_time_ff     <= pair_time_in;
         stable_switch_ff <= stable_switch_in;
         last_switch_ff   <= last_switch_in;
         switch_time_ff   <= switch_time_in;
         pressed_ff       <= pressed_in;
      end
   end

   // Result of this item, with the held flag after its update.
   assign result.step_right  = pair_accept && (dir == dqe_pkg::DIR_RIGHT)
                            && (raw_pair == last_pair_ff);
   assign result.step_left   = pair_accept && (dir == dqe_pkg::DIR_LEFT);
   assign result.click       = switch_accept && !item.level_switch;
   assign result.switch_held = (item.level_switch == last_switch_ff && switch_accept)
                            ? !item.level_switch : pressed_ff;

endmodule

FILE: design/debounced_quadrature_encoder_top.sv
// Items pass the input register, then their results the result register.
// Throughput: one item per cycle; a stalled result holds the input.
// The debounce state is read and written in the single pass between the
// input register and the result register.
// Reset (synchronous, active high) empties both registers, restores the
// debounce state (switch released, pair 00) and the hold times 2 and 10 ms.
`include "assert_macros.svh"

module debounced_quadrature_encoder_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dqe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dqe_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   dqe_pkg::cfg_type cfg;
   dqe_pkg::req_type in_data_ff;
   dqe_pkg::rsp_type out_data_ff;
   dqe_pkg::rsp_type result;
   logic             in_valid_ff, in_valid_in;
   logic             out_valid_ff, out_valid_in;
   logic             advance;
   logic             req_transfer;

   dqe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dqe_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (in_data_ff),
      .update (advance),
      .result (result)
   );

   // The input register moves on whenever the result register is free or
   // its result is taken in the same cycle.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign req_transfer = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers load on a transfer only.
   always_ff @(posedge clock) begin
      if (req_transfer) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `DQE_ASSERT(a_single_direction, rsp_valid |-> !(rsp_data.step_right && rsp_data.step_left), "both step directions in one result")
   `DQE_ASSERT(a_click_held, (rsp_valid && rsp_data.click) |-> rsp_data.switch_held, "click without held switch")
   `DQE_ASSERT(a_stage_holds, (in_valid_ff && out_valid_ff && !rsp_ready) |=> in_valid_ff, "input register lost an item under stall")
   `DQE_ASSERT_ALWAYS(a_reset_empty, reset |=> (!rsp_valid && !in_valid_ff), "pipeline not empty after reset")

endmodule
